// File: rtl/core/apng_det_pkg.sv
package apng_det_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_SKIP = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    // verdict codes
    typedef enum logic [2:0] {
        OUT_ACTL  = 3'd0,
        OUT_IDAT  = 3'd1,
        OUT_IEND  = 3'd2,
        OUT_BADSG = 3'd3,
        OUT_TRUNC = 3'd4
    } outcome_t;

    localparam logic [31:0] TYPE_ACTL = 32'h6163544C;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454E44;

    // crc bytes that follow every chunk payload
    localparam logic [32:0] CRC_BYTES = 33'd4;

    localparam logic [2:0] SIG_LAST_POS  = 3'd7;
    localparam logic [2:0] WORD_LAST_POS = 3'd3;

    // png file signature, one byte per position
    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/animated_png_chunk_detector_top.sv
// animated png detector
//
// input channel s_*: one item per file byte. s_tdata carries the byte,
// s_tuser marks the first byte of a file (restarts the parser, the byte
// itself is checked as signature byte 0), s_tlast marks the final byte.
// result channel m_*: at most one item per file, the verdict. bit 0 of
// m_tdata is set only for an animation control chunk found before any
// image data or end chunk; bits 3:1 hold the outcome code.
//
// one input item is taken every cycle while s_tready is high. the parser
// state and the verdict are both updated at the accepting edge, so a
// verdict appears on m_* in the cycle after the byte that caused it. the
// only path between registers is one byte compare, a 33-bit add or
// decrement and a 32-bit type compare.
//
// reset (aresetn low, synchronous) puts the parser in the signature
// phase and empties the result register; a stream that starts without a
// first mark is parsed from there.
// while a verdict waits and m_tready is low, s_tready drops; it rises
// again in the cycle the verdict is taken, so no item is lost.
module animated_png_chunk_detector_top
    import apng_det_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // data_byte
    input  logic       s_tuser,    // first_byte
    input  logic       s_tlast,    // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // is_animated, outcome[2:0], zero pad
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  byte_pos_reg, byte_pos_next;
    logic [31:0] chunk_len_reg, chunk_len_next;
    logic [23:0] type_prefix_reg, type_prefix_next;
    logic [32:0] skip_reg, skip_next;

    logic        m_valid_reg, m_valid_next;
    outcome_t    outcome_reg, outcome_next;

    logic        s_fire;
    logic        verdict_valid;
    outcome_t    verdict_code;

    // state the current byte sees: a first mark restarts the parser
    phase_t      cur_phase;
    logic [2:0]  cur_pos;
    logic [31:0] cur_len;
    logic [23:0] cur_prefix;
    logic [31:0] type_word;
    logic [32:0] skip_dec;

    assign s_fire   = s_tvalid && s_tready;
    // result register frees up when empty or being drained
    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        cur_phase  = s_tuser ? PH_SIG : phase_reg;
        cur_pos    = s_tuser ? 3'd0 : byte_pos_reg;
        cur_len    = s_tuser ? 32'd0 : chunk_len_reg;
        cur_prefix = s_tuser ? 24'd0 : type_prefix_reg;
        type_word  = {cur_prefix, s_tdata};
        skip_dec   = (skip_reg != 33'd0) ? (skip_reg - 33'd1) : skip_reg;
    end

    // verdict for the current byte
    always_comb begin
        verdict_valid = 1'b0;
        verdict_code  = OUT_TRUNC;
        case (cur_phase)
            PH_SIG: begin
                if (s_tdata != sig_byte(cur_pos)) begin
                    verdict_valid = 1'b1;
                    verdict_code  = OUT_BADSG;
                end
            end
            PH_TYPE: begin
                if (cur_pos >= WORD_LAST_POS) begin
                    if (type_word == TYPE_ACTL) begin
                        verdict_valid = 1'b1;
                        verdict_code  = OUT_ACTL;
                    end else if (type_word == TYPE_IDAT) begin
                        verdict_valid = 1'b1;
                        verdict_code  = OUT_IDAT;
                    end else if (type_word == TYPE_IEND) begin
                        verdict_valid = 1'b1;
                        verdict_code  = OUT_IEND;
                    end
                end
            end
            default: begin
            end
        endcase
        // end of file with no verdict yet
        if (!verdict_valid && cur_phase != PH_DONE && s_tlast) begin
            verdict_valid = 1'b1;
            verdict_code  = OUT_TRUNC;
        end
    end

    // parser next state
    always_comb begin
        phase_next       = phase_reg;
        byte_pos_next    = byte_pos_reg;
        chunk_len_next   = chunk_len_reg;
        type_prefix_next = type_prefix_reg;
        skip_next        = skip_reg;
        if (s_fire) begin
            phase_next       = cur_phase;
            byte_pos_next    = cur_pos;
            chunk_len_next   = cur_len;
            type_prefix_next = cur_prefix;
            case (cur_phase)
                PH_SIG: begin
                    if (cur_pos >= SIG_LAST_POS) begin
                        byte_pos_next = 3'd0;
                        phase_next    = PH_LEN;
                    end else begin
                        byte_pos_next = cur_pos + 3'd1;
                    end
                end
                PH_LEN: begin
                    chunk_len_next = {cur_len[23:0], s_tdata};
                    if (cur_pos >= WORD_LAST_POS) begin
                        byte_pos_next    = 3'd0;
                        type_prefix_next = 24'd0;
                        phase_next       = PH_TYPE;
                    end else begin
                        byte_pos_next = cur_pos + 3'd1;
                    end
                end
                PH_TYPE: begin
                    if (cur_pos >= WORD_LAST_POS) begin
                        skip_next     = {1'b0, cur_len} + CRC_BYTES;
                        byte_pos_next = 3'd0;
                        phase_next    = PH_SKIP;
                    end else begin
                        type_prefix_next = type_word[23:0];
                        byte_pos_next    = cur_pos + 3'd1;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 33'd0) begin
                        chunk_len_next = 32'd0;
                        byte_pos_next  = 3'd0;
                        phase_next     = PH_LEN;
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
            // any verdict ends the file
            if (verdict_valid) begin
                phase_next = PH_DONE;
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        outcome_next = outcome_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire && verdict_valid) begin
            m_valid_next = 1'b1;
            outcome_next = verdict_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SIG;
            byte_pos_reg <= 3'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            byte_pos_reg <= byte_pos_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chunk_len_reg   <= chunk_len_next;
        type_prefix_reg <= type_prefix_next;
        skip_reg        <= skip_next;
        outcome_reg     <= outcome_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, outcome_reg, (outcome_reg == OUT_ACTL)};

`ifndef SYNTH
    a_verdict_ends_file: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && verdict_valid) |=> (phase_reg == PH_DONE && m_valid_reg))
        else $error("verdict did not close the file");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_valid_reg)
        else $error("input stalled with empty result register");

    a_word_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LEN || phase_reg == PH_TYPE) |-> (byte_pos_reg <= WORD_LAST_POS))
        else $error("byte position out of range in length or type");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_SKIP) |-> (skip_reg != 33'd0))
        else $error("skip phase with empty skip counter");

    a_animated_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_tdata[0] == (m_tdata[3:1] == OUT_ACTL)))
        else $error("animated flag disagrees with outcome");
`endif

endmodule
